// File: rtl/ctpe_pkg.sv
// Shared constants, byte-source codes and control structures of the tag path encoder.
`timescale 1ns / 1ps
`default_nettype none

package ctpe_pkg;

    // Encoded path segment codes.
    localparam logic [7:0] SEG_NAME   = 8'h91;
    localparam logic [7:0] SEG_ELEM8  = 8'h28;
    localparam logic [7:0] SEG_ELEM16 = 8'h29;
    localparam logic [7:0] SEG_ELEM32 = 8'h2A;
    localparam logic [7:0] PAD_BYTE   = 8'h00;

    // Characters of the address syntax.
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [15:0] LEN_SAT = 16'hFFFF;

    // Where the next output byte comes from.
    typedef logic [2:0] byte_src_t;
    localparam byte_src_t SRC_NAME_HDR  = 3'd0;
    localparam byte_src_t SRC_NAME_LEN  = 3'd1;
    localparam byte_src_t SRC_NAME_DATA = 3'd2;
    localparam byte_src_t SRC_PAD       = 3'd3;
    localparam byte_src_t SRC_SEG       = 3'd4;
    localparam byte_src_t SRC_MARK      = 3'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      accept;
        logic      emit;
        byte_src_t src;
        logic      run_last;
        logic      path_end;
        logic      rd_en;
        logic      idx_clr;
        logic      idx_inc;
        logic      name_done;
        logic      seg_done;
        logic      path_clear;
    } ctpe_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic plan_name;
        logic plan_seg_sep;
        logic plan_seg_end;
        logic plan_last;
        logic name_odd;
        logic name_data_last;
        logic seg_last;
    } ctpe_status_t;

endpackage

`default_nettype wire

// File: rtl/ctpe_if.sv
// Handshake interfaces for the character input and the path byte output.
`timescale 1ns / 1ps
`default_nettype none

interface ctpe_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last_char;

    modport source (output valid, output ch, output last_char, input ready);
    modport sink (input valid, input ch, input last_char, output ready);
endinterface

interface ctpe_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_byte;
    logic        run_last;
    logic        path_end;
    logic [15:0] path_length;
    logic        name_too_long;

    modport source (output valid, output out_byte, output is_byte, output run_last,
                    output path_end, output path_length, output name_too_long,
                    input ready);
    modport sink (input valid, input out_byte, input is_byte, input run_last,
                  input path_end, input path_length, input name_too_long,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/cip_tag_path_encoder.sv
// Top level of the tag path encoder: controller, datapath and channel wiring.
`timescale 1ns / 1ps
`default_nettype none

// The encoder takes a tag address such as A.B[3,70000] one character per
// transaction on tag_char, with last_char set on the final character, and
// produces the encoded request path on path_byte, one byte per transaction.
// Name runs become 0x91, the length, the characters and a zero pad byte when
// the length is odd; names longer than MAX_NAME characters are cut short and
// name_too_long is raised on every later byte of that path. Bracketed decimal
// indices become 0x28, 0x29 or 0x2A element segments according to their size,
// with the index saturating at 32 bits. run_last marks the last byte caused by
// a character and path_end the last byte of the whole path, where path_length
// holds the byte total (saturating at 65535). A final character that causes no
// byte yields a single end marker with is_byte low. The controller accepts a
// character in its idle state and then passes through a dispatch state; a
// character that produces nothing goes back to idle from there. Each name
// byte is read from the name buffer RAM and then loaded into the output
// register; header, pad and segment bytes are loaded directly, and the
// dispatch state follows every name or segment group. Each load waits while
// the output register is full and path_byte.ready is low. The output register
// lets a finished byte wait for its consumer while the block moves on.
module cip_tag_path_encoder
    import ctpe_pkg::*;
#(
    parameter int MAX_NAME = 40
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ctpe_char_if.sink     tag_char,
    ctpe_byte_if.source   path_byte
);

    ctpe_cmd_t    cmd;
    ctpe_status_t status;
    logic         ctrl_in_ready;

    // The controller owns the handshake on the input side and decides, from
    // the plan the datapath works out for the character being offered, which
    // groups of bytes have to be produced.
    ctpe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (tag_char.valid),
        .in_ready (ctrl_in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign tag_char.ready = ctrl_in_ready;

    // The datapath holds the parse state, the name buffer and the output
    // register that drives path_byte.
    ctpe_datapath #(
        .MAX_NAME (MAX_NAME)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (tag_char.ch),
        .in_last_char  (tag_char.last_char),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (path_byte.ready),
        .out_valid     (path_byte.valid),
        .out_byte      (path_byte.out_byte),
        .is_byte       (path_byte.is_byte),
        .run_last      (path_byte.run_last),
        .path_end      (path_byte.path_end),
        .path_length   (path_byte.path_length),
        .name_too_long (path_byte.name_too_long)
    );

endmodule

`default_nettype wire

// File: rtl/ctpe_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ctpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [ADDR_W-1:0]      waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic                   re,
    input  wire logic [ADDR_W-1:0]      raddr,
    output logic      [WIDTH-1:0]       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/ctpe_ctrl.sv
// Controller state machine that sequences the output bytes of each character.
`timescale 1ns / 1ps
`default_nettype none

module ctpe_ctrl
    import ctpe_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire ctpe_status_t status,
    output ctpe_cmd_t         cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_NEXT = 4'd1;
    localparam logic [3:0] ST_NHDR = 4'd2;
    localparam logic [3:0] ST_NLEN = 4'd3;
    localparam logic [3:0] ST_NRD  = 4'd4;
    localparam logic [3:0] ST_NDAT = 4'd5;
    localparam logic [3:0] ST_NPAD = 4'd6;
    localparam logic [3:0] ST_SEG  = 4'd7;
    localparam logic [3:0] ST_MARK = 4'd8;

    logic [3:0] state_reg,     state_next;
    logic       pend_name_reg, pend_name_next;
    logic       pend_sep_reg,  pend_sep_next;
    logic       pend_end_reg,  pend_end_next;
    logic       last_reg,      last_next;
    logic       emitted_reg,   emitted_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        pend_name_next = pend_name_reg;
        pend_sep_next  = pend_sep_reg;
        pend_end_next  = pend_end_reg;
        last_next      = last_reg;
        emitted_next   = emitted_reg;
        cmd            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept     = 1'b1;
                    pend_name_next = status.plan_name;
                    pend_sep_next  = status.plan_seg_sep;
                    pend_end_next  = status.plan_seg_end;
                    last_next      = status.plan_last;
                    emitted_next   = 1'b0;
                    state_next     = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (pend_name_reg)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_NHDR;
                end
                else if (pend_sep_reg || pend_end_reg)
                begin
                    state_next = ST_SEG;
                end
                else if (last_reg && !emitted_reg)
                begin
                    state_next = ST_MARK;
                end
                else
                begin
                    cmd.path_clear = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_NHDR:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_NAME_HDR;
                    state_next = ST_NLEN;
                end
            end
            ST_NLEN:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.src    = SRC_NAME_LEN;
                    state_next = ST_NRD;
                end
            end
            ST_NRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_NDAT;
            end
            ST_NDAT:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.src     = SRC_NAME_DATA;
                    cmd.idx_inc = 1'b1;
                    if (!status.name_data_last)
                    begin
                        state_next = ST_NRD;
                    end
                    else if (status.name_odd)
                    begin
                        state_next = ST_NPAD;
                    end
                    else
                    begin
                        cmd.run_last   = !(pend_sep_reg || pend_end_reg);
                        cmd.path_end   = !(pend_sep_reg || pend_end_reg) && last_reg;
                        cmd.name_done  = 1'b1;
                        pend_name_next = 1'b0;
                        state_next     = ST_NEXT;
                    end
                end
            end
            ST_NPAD:
            begin
                if (status.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.src        = SRC_PAD;
                    cmd.run_last   = !(pend_sep_reg || pend_end_reg);
                    cmd.path_end   = !(pend_sep_reg || pend_end_reg) && last_reg;
                    cmd.name_done  = 1'b1;
                    pend_name_next = 1'b0;
                    state_next     = ST_NEXT;
                end
            end
            ST_SEG:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.src  = SRC_SEG;
                    if (status.seg_last)
                    begin
                        cmd.seg_done = 1'b1;
                        cmd.run_last = !(pend_sep_reg && pend_end_reg);
                        cmd.path_end = !(pend_sep_reg && pend_end_reg) && last_reg;
                        if (pend_sep_reg)
                        begin
                            pend_sep_next = 1'b0;
                        end
                        else
                        begin
                            pend_end_next = 1'b0;
                        end
                        state_next = ST_NEXT;
                    end
                end
            end
            ST_MARK:
            begin
                if (status.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.src        = SRC_MARK;
                    cmd.run_last   = 1'b1;
                    cmd.path_end   = 1'b1;
                    cmd.path_clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.emit)
        begin
            emitted_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_name_reg <= 1'b0;
            pend_sep_reg  <= 1'b0;
            pend_end_reg  <= 1'b0;
            last_reg      <= 1'b0;
            emitted_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_name_reg <= pend_name_next;
            pend_sep_reg  <= pend_sep_next;
            pend_end_reg  <= pend_end_next;
            last_reg      <= last_next;
            emitted_reg   <= emitted_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ctpe_datapath.sv
// Datapath: parse state, name buffer, index accumulator, byte selection and output register.
`timescale 1ns / 1ps
`default_nettype none

module ctpe_datapath
    import ctpe_pkg::*;
#(
    parameter int MAX_NAME = 40
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  in_ch,
    input  wire logic        in_last_char,
    input  wire ctpe_cmd_t   cmd,
    output ctpe_status_t     status,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic [7:0]       out_byte,
    output logic             is_byte,
    output logic             run_last,
    output logic             path_end,
    output logic [15:0]      path_length,
    output logic             name_too_long
);

    localparam int CW = $clog2(MAX_NAME + 1);
    localparam int AW = (MAX_NAME > 1) ? $clog2(MAX_NAME) : 1;

    logic          in_br_reg,   in_br_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [CW-1:0] idx_reg,     idx_next;
    logic [31:0]   acc_reg,     acc_next;
    logic          dd_reg,      dd_next;
    logic          sd_reg,      sd_next;
    logic          trunc_reg,   trunc_next;
    logic [15:0]   total_reg,   total_next;
    logic [2:0]    pos_reg,     pos_next;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          is_byte_reg;
    logic          run_last_reg;
    logic          path_end_reg;
    logic [15:0]   path_length_reg;
    logic          name_too_long_reg;

    logic          is_sep;
    logic          is_digit;
    logic          is_space;
    logic          can_store;
    logic          store;
    logic [CW-1:0] count_after;
    logic [35:0]   prod;
    logic [7:0]    ram_rdata;
    logic          big;
    logic          mid;
    logic [7:0]    seg_byte;
    logic [7:0]    sel_byte;
    logic [15:0]   total_inc;

    assign is_sep    = in_ch inside {CH_COMMA, CH_RBRACK};
    assign is_digit  = in_ch inside {[CH_ZERO:CH_NINE]};
    assign is_space  = in_ch inside {CH_SPACE, [CH_TAB:CH_CR]};
    assign can_store = !in_br_reg && (in_ch != CH_DOT) && (in_ch != CH_LBRACK);
    assign store     = cmd.accept && can_store && (count_reg < CW'(MAX_NAME));

    // Ten times the accumulator plus the digit; anything above 32 bits saturates.
    assign prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + {32'b0, in_ch[3:0]};

    assign count_after = (can_store && (count_reg < CW'(MAX_NAME)))
                       ? count_reg + CW'(1) : count_reg;

    always_comb
    begin
        status.out_free       = !out_valid_reg || out_ready;
        status.plan_name      = !in_br_reg && (count_after != '0)
                              && ((in_ch == CH_DOT) || (in_ch == CH_LBRACK) || in_last_char);
        status.plan_seg_sep   = in_br_reg && is_sep;
        status.plan_seg_end   = in_last_char
                              && ((in_br_reg && (in_ch != CH_RBRACK))
                                  || (!in_br_reg && (in_ch == CH_LBRACK)));
        status.plan_last      = in_last_char;
        status.name_odd       = count_reg[0];
        status.name_data_last = ((idx_reg + CW'(1)) == count_reg);
        if (big)
        begin
            status.seg_last = (pos_reg == 3'd5);
        end
        else if (mid)
        begin
            status.seg_last = (pos_reg == 3'd3);
        end
        else
        begin
            status.seg_last = (pos_reg == 3'd1);
        end
    end

    always_comb
    begin
        in_br_next = in_br_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        dd_next    = dd_reg;
        sd_next    = sd_reg;
        trunc_next = trunc_reg;
        total_next = total_reg;
        pos_next   = pos_reg;

        if (cmd.accept)
        begin
            if (in_br_reg)
            begin
                if (!is_sep && !dd_reg)
                begin
                    if (is_digit)
                    begin
                        acc_next = (prod[35:32] != 4'b0) ? 32'hFFFF_FFFF : prod[31:0];
                        sd_next  = 1'b1;
                    end
                    else if (!(is_space && !sd_reg))
                    begin
                        dd_next = 1'b1;
                    end
                end
                if (in_ch == CH_RBRACK)
                begin
                    in_br_next = 1'b0;
                end
            end
            else if (in_ch == CH_LBRACK)
            begin
                in_br_next = 1'b1;
                acc_next   = '0;
                dd_next    = 1'b0;
                sd_next    = 1'b0;
            end
            else if (in_ch != CH_DOT)
            begin
                if (store)
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    trunc_next = 1'b1;
                end
            end
        end

        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end
        if (cmd.emit && (cmd.src == SRC_SEG))
        begin
            pos_next = pos_reg + 3'd1;
        end
        if (cmd.emit && (cmd.src != SRC_MARK))
        begin
            total_next = total_inc;
        end
        if (cmd.name_done)
        begin
            count_next = '0;
        end
        if (cmd.seg_done)
        begin
            acc_next = '0;
            dd_next  = 1'b0;
            sd_next  = 1'b0;
            pos_next = '0;
        end
        if (cmd.path_clear)
        begin
            in_br_next = 1'b0;
            count_next = '0;
            acc_next   = '0;
            dd_next    = 1'b0;
            sd_next    = 1'b0;
            trunc_next = 1'b0;
            total_next = '0;
            pos_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_br_reg <= 1'b0;
            count_reg <= '0;
            idx_reg   <= '0;
            acc_reg   <= '0;
            dd_reg    <= 1'b0;
            sd_reg    <= 1'b0;
            trunc_reg <= 1'b0;
            total_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            in_br_reg <= in_br_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            dd_reg    <= dd_next;
            sd_reg    <= sd_next;
            trunc_reg <= trunc_next;
            total_reg <= total_next;
            pos_reg   <= pos_next;
        end
    end

    ctpe_ram #(
        .WIDTH (8),
        .DEPTH (MAX_NAME)
    ) u_name_ram (
        .clk   (clk),
        .we    (store),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_ch),
        .re    (cmd.rd_en),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Element segment: width class follows the value, bytes go out little-endian.
    assign big = |acc_reg[31:16];
    assign mid = |acc_reg[15:8];

    always_comb
    begin
        case (pos_reg)
            3'd0:
            begin
                seg_byte = big ? SEG_ELEM32 : (mid ? SEG_ELEM16 : SEG_ELEM8);
            end
            3'd1:
            begin
                seg_byte = (big || mid) ? PAD_BYTE : acc_reg[7:0];
            end
            3'd2:    seg_byte = acc_reg[7:0];
            3'd3:    seg_byte = acc_reg[15:8];
            3'd4:    seg_byte = acc_reg[23:16];
            default: seg_byte = acc_reg[31:24];
        endcase
    end

    always_comb
    begin
        case (cmd.src)
            SRC_NAME_HDR:  sel_byte = SEG_NAME;
            SRC_NAME_LEN:  sel_byte = 8'(count_reg);
            SRC_NAME_DATA: sel_byte = ram_rdata;
            SRC_SEG:       sel_byte = seg_byte;
            default:       sel_byte = PAD_BYTE;
        endcase
    end

    assign total_inc = (total_reg == LEN_SAT) ? total_reg : total_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_byte_reg      <= sel_byte;
            is_byte_reg       <= (cmd.src != SRC_MARK);
            run_last_reg      <= cmd.run_last;
            path_end_reg      <= cmd.path_end;
            path_length_reg   <= (cmd.src == SRC_MARK) ? total_reg : total_inc;
            name_too_long_reg <= trunc_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign is_byte       = is_byte_reg;
    assign run_last      = run_last_reg;
    assign path_end      = path_end_reg;
    assign path_length   = path_length_reg;
    assign name_too_long = name_too_long_reg;

endmodule

`default_nettype wire

// File: rtl/ctpe_checker.sv
// Port-level assertions for the tag path encoder and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module ctpe_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_last_char,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  out_byte,
    input wire logic        is_byte,
    input wire logic        run_last,
    input wire logic        path_end,
    input wire logic [15:0] path_length
);

    // A result that has been offered stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("path byte withdrawn before it was taken");

    // An end marker closes both the character and the path and carries no byte.
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_byte |-> path_end && run_last && (out_byte == 8'h00))
        else $error("malformed end marker");

    // Back-to-back path bytes of one path count up by one.
    a_length_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(out_valid && out_ready && is_byte && !path_end && (path_length != 16'hFFFF))
        && out_valid && out_ready && is_byte
        |-> path_length == $past(path_length) + 16'd1)
        else $error("path length did not advance by one");

    // The final character always produces at least one result, so the block is busy next.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last_char |=> !in_ready)
        else $error("final character accepted without producing a result");

endmodule

bind cip_tag_path_encoder ctpe_checker u_ctpe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (tag_char.valid),
    .in_ready     (tag_char.ready),
    .in_last_char (tag_char.last_char),
    .out_valid    (path_byte.valid),
    .out_ready    (path_byte.ready),
    .out_byte     (path_byte.out_byte),
    .is_byte      (path_byte.is_byte),
    .run_last     (path_byte.run_last),
    .path_end     (path_byte.path_end),
    .path_length  (path_byte.path_length)
);

`default_nettype wire
